@@ rtl/core/frs_pkg.sv @@
// free id range set: shared types and operation codes
// used by frs_ctrl, frs_dp and free_id_range_set
`default_nettype none
package frs_pkg;

  typedef enum logic [2:0] {
    FN_ADD    = 3'd0,
    FN_HAS    = 3'd1,
    FN_GET    = 3'd2,
    FN_SELECT = 3'd3,
    FN_START  = 3'd4
  } func_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic wr1;
    logic shift;
    logic wr2;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/core/free_id_range_set.sv @@
// free id range set top level: stream ports around controller and datapath
// depends on frs_pkg, frs_ctrl, frs_dp, frs_ram
//
// keeps a sorted table of disjoint free id ranges in one memory
// input channel s_axis: one transfer is one request (add, has, get,
// select, start); tuser carries the operation code
// output channel m_axis: exactly one result transfer per request with the
// taken id in tdata and hit and overflow flags in tuser
// one request is worked on at a time; s_axis_tready is high only while
// the block is free to start a new request
// a request first walks the table of N ranges once through the single
// memory read port to find the slot, then the M entries behind it are
// moved one per cycle for an insert or removal; the block returns to idle
// and can take the next request in the cycle after the result is loaded
// the result sits in an output register, so a new request is accepted
// while the previous result still waits for m_axis_tready
// a stalled receiver only holds the request that is finishing
// reset empties the set at once; the memory needs no clearing pass
`default_nettype none
module free_id_range_set
  import frs_pkg::*;
#(
  parameter int MAX_RANGES = 64,
  parameter int ID_BITS    = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // range_low [31:0], range_high [63:32]
  input  wire logic [2:0]  s_axis_tuser,  // func [2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // result_id [31:0]
  output logic [1:0]       m_axis_tuser   // hit [0], overflow [1]
);

  cmd_t cmd;
  sts_t sts;

  frs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  frs_dp #(.MAX_RANGES(MAX_RANGES), .ID_BITS(ID_BITS)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .func_i    (s_axis_tuser),
    .lo_i      (s_axis_tdata[31:0]),
    .hi_i      (s_axis_tdata[63:32]),
    .out_vld_o (m_axis_tvalid),
    .out_rdy_i (m_axis_tready),
    .out_id_o  (m_axis_tdata),
    .out_hit_o (m_axis_tuser[0]),
    .out_ovf_o (m_axis_tuser[1])
  );

endmodule
`default_nettype wire

@@ rtl/core/frs_ram.sv @@
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module frs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/core/frs_ctrl.sv @@
// free id range set controller: sequences scan, decide, writes and shift
// depends on frs_pkg
`default_nettype none
module frs_ctrl
  import frs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_valid_i,
  output logic      s_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_DECIDE = 7'b0000100,
    ST_WR1    = 7'b0001000,
    ST_SHIFT  = 7'b0010000,
    ST_WR2    = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.walk_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_WR1;
      end
      ST_WR1: begin
        cmd_o.wr1 = 1'b1;
        state_d   = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.walk_done) state_d = ST_WR2;
      end
      ST_WR2: begin
        cmd_o.wr2 = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_SCAN) else $error("load left idle wrongly");
  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> s_ready_o) else $error("finish did not return to idle");
  a_decide_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.decide |=> !cmd_o.decide) else $error("decide repeated");
`endif

endmodule
`default_nettype wire

@@ rtl/core/frs_dp.sv @@
// free id range set datapath: range memory, walk engine, plan and result
// depends on frs_pkg and frs_ram
`default_nettype none
module frs_dp
  import frs_pkg::*;
#(
  parameter int MAX_RANGES = 64,
  parameter int ID_BITS    = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o,
  input  wire logic [2:0]  func_i,
  input  wire logic [31:0] lo_i,
  input  wire logic [31:0] hi_i,
  output logic             out_vld_o,
  input  wire logic        out_rdy_i,
  output logic [31:0]      out_id_o,
  output logic             out_hit_o,
  output logic             out_ovf_o
);

  localparam int IW = (ID_BITS < 32) ? ID_BITS : 32;
  localparam int AW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_RANGES);

  logic [2:0]    func_q;
  logic [IW-1:0] lo_q, hi_q;
  logic [CW-1:0] cnt_q, cnt_nxt_q;
  logic [AW-1:0] rd_idx_q, rd_pos_q;
  logic [CW-1:0] rem_q;
  logic          rd_vld_q, rd_dn_q;
  logic          a_fnd_q, b_fnd_q, has_q;
  logic [AW-1:0] a_q;
  logic [CW-1:0] b_q;
  logic [IW-1:0] sa_q, ea_q, eb_q;
  logic          w1_q, w2_q, sh_up_q;
  logic [AW-1:0] w1_addr_q, w2_addr_q;
  logic [IW-1:0] w1_s_q, w1_e_q, w2_s_q, w2_e_q;
  logic [CW-1:0] sh_d_q;
  logic [IW-1:0] res_id_q;
  logic          res_hit_q, res_ovf_q;
  logic          out_vld_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [2*IW-1:0] ram_wdata, ram_rdata;
  logic [IW-1:0] rd_s, rd_e;
  logic          is_add, a_cond, a_here, step;

  // plan
  logic          p_w1, p_w2, p_up, p_dn, p_hit, p_ovf;
  logic [AW-1:0] p_w1_addr, p_w2_addr, p_src, ai, k;
  logic [IW-1:0] p_w1_s, p_w1_e, p_w2_s, p_w2_e, p_id, id_sel, id_inc;
  logic [CW-1:0] p_rem, p_d, p_cnt, d_merge;
  logic          full;

  frs_ram #(.WIDTH(2 * IW), .DEPTH(MAX_RANGES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd_s   = ram_rdata[IW-1:0];
  assign rd_e   = ram_rdata[2*IW-1:IW];
  assign is_add = func_q == FN_ADD;
  assign a_cond = is_add ? (rd_e >= lo_q) : (rd_e > lo_q);
  assign a_here = a_fnd_q | a_cond;
  assign step   = (cmd_i.scan | cmd_i.shift) & (rem_q != '0);

  assign sts_o.walk_done = (rem_q == '0) & !rd_vld_q;
  assign sts_o.out_free  = !out_vld_q | out_rdy_i;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w1_addr_q;
    ram_wdata = {w1_e_q, w1_s_q};
    if (cmd_i.wr1 && w1_q) begin
      ram_we = 1'b1;
    end else if (cmd_i.wr2 && w2_q) begin
      ram_we    = 1'b1;
      ram_waddr = w2_addr_q;
      ram_wdata = {w2_e_q, w2_s_q};
    end else if (cmd_i.shift && rd_vld_q) begin
      ram_we    = 1'b1;
      ram_waddr = sh_up_q ? rd_pos_q + AW'(1) : rd_pos_q - sh_d_q[AW-1:0];
      ram_wdata = ram_rdata;
    end
  end

  assign ai      = a_fnd_q ? a_q : cnt_q[AW-1:0];
  assign k       = a_q;
  assign full    = cnt_q >= MaxCnt;
  assign id_sel  = (lo_q < sa_q) ? sa_q : lo_q;
  assign id_inc  = id_sel + IW'(1);
  assign d_merge = b_q - CW'(ai) - CW'(1);

  always_comb begin
    p_w1 = 1'b0; p_w2 = 1'b0; p_up = 1'b0; p_dn = 1'b0;
    p_hit = 1'b0; p_ovf = 1'b0; p_id = '0;
    p_w1_addr = ai; p_w1_s = lo_q; p_w1_e = hi_q;
    p_w2_addr = ai; p_w2_s = lo_q; p_w2_e = hi_q;
    p_src = '0; p_rem = '0; p_d = CW'(1); p_cnt = cnt_q;
    case (func_q)
      FN_ADD: begin
        if (lo_q < hi_q) begin
          if (!b_fnd_q) begin
            if (full) begin
              p_ovf = 1'b1;
            end else begin
              p_up  = 1'b1;
              p_src = cnt_q[AW-1:0] - AW'(1);
              p_rem = cnt_q - CW'(ai);
              p_w2  = 1'b1;
              p_cnt = cnt_q + CW'(1);
              p_hit = 1'b1;
            end
          end else begin
            p_w1   = 1'b1;
            p_w1_s = (sa_q < lo_q) ? sa_q : lo_q;
            p_w1_e = (eb_q > hi_q) ? eb_q : hi_q;
            p_hit  = 1'b1;
            if (d_merge != '0) begin
              p_dn  = 1'b1;
              p_src = b_q[AW-1:0];
              p_rem = cnt_q - b_q;
              p_d   = d_merge;
              p_cnt = cnt_q - d_merge;
            end
          end
        end
      end
      FN_HAS: p_hit = has_q;
      FN_GET, FN_SELECT, FN_START: begin
        if (a_fnd_q && !(func_q == FN_SELECT && lo_q < sa_q)) begin
          p_id      = id_sel;
          p_hit     = 1'b1;
          p_w1_addr = k;
          if (id_sel == sa_q) begin
            if (id_inc == ea_q) begin
              p_dn  = 1'b1;
              p_src = k + AW'(1);
              p_rem = cnt_q - CW'(k) - CW'(1);
              p_cnt = cnt_q - CW'(1);
            end else begin
              p_w1   = 1'b1;
              p_w1_s = id_inc;
              p_w1_e = ea_q;
            end
          end else if (id_inc == ea_q) begin
            p_w1   = 1'b1;
            p_w1_s = sa_q;
            p_w1_e = id_sel;
          end else if (full) begin
            p_hit = 1'b0;
            p_id  = '0;
            p_ovf = 1'b1;
          end else begin
            p_w1      = 1'b1;
            p_w1_s    = sa_q;
            p_w1_e    = id_sel;
            p_up      = 1'b1;
            p_src     = cnt_q[AW-1:0] - AW'(1);
            p_rem     = cnt_q - CW'(k) - CW'(1);
            p_w2      = 1'b1;
            p_w2_addr = k + AW'(1);
            p_w2_s    = id_inc;
            p_w2_e    = ea_q;
            p_cnt     = cnt_q + CW'(1);
          end
        end
      end
      default: p_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rem_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= step;
      if (step) rem_q <= rem_q - CW'(1);
      if (cmd_i.load) rem_q <= cnt_q;
      if (cmd_i.decide) rem_q <= p_rem;
      if (cmd_i.finish) begin
        cnt_q     <= cnt_nxt_q;
        out_vld_q <= 1'b1;
      end else if (out_rdy_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      rd_pos_q <= rd_idx_q;
      rd_idx_q <= rd_dn_q ? rd_idx_q - AW'(1) : rd_idx_q + AW'(1);
    end
    if (cmd_i.load) begin
      func_q   <= func_i;
      lo_q     <= (func_i == FN_GET) ? '0 : lo_i[IW-1:0];
      hi_q     <= hi_i[IW-1:0];
      rd_idx_q <= '0;
      rd_dn_q  <= 1'b0;
      a_fnd_q  <= 1'b0;
      b_fnd_q  <= 1'b0;
      has_q    <= 1'b0;
    end
    if (cmd_i.scan && rd_vld_q) begin
      if (!a_fnd_q && a_cond) begin
        a_fnd_q <= 1'b1;
        a_q     <= rd_pos_q;
        sa_q    <= rd_s;
        ea_q    <= rd_e;
      end
      if (is_add && a_here && rd_s <= hi_q) begin
        b_fnd_q <= 1'b1;
        b_q     <= CW'(rd_pos_q) + CW'(1);
        eb_q    <= rd_e;
      end
      if (lo_q >= rd_s && lo_q < rd_e) has_q <= 1'b1;
    end
    if (cmd_i.decide) begin
      w1_q      <= p_w1;
      w1_addr_q <= p_w1_addr;
      w1_s_q    <= p_w1_s;
      w1_e_q    <= p_w1_e;
      w2_q      <= p_w2;
      w2_addr_q <= p_w2_addr;
      w2_s_q    <= p_w2_s;
      w2_e_q    <= p_w2_e;
      sh_up_q   <= p_up;
      sh_d_q    <= p_d;
      rd_idx_q  <= p_src;
      rd_dn_q   <= p_up;
      cnt_nxt_q <= p_cnt;
      res_id_q  <= p_id;
      res_hit_q <= p_hit;
      res_ovf_q <= p_ovf;
    end
    if (cmd_i.finish) begin
      out_id_o  <= 32'(res_id_q);
      out_hit_o <= res_hit_q;
      out_ovf_o <= res_ovf_q;
    end
  end

  assign out_vld_o = out_vld_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt) else $error("range count above capacity");
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> !ram_we) else $error("memory written during scan");
  a_hit_excl_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |-> !(p_hit && p_ovf)) else $error("hit and overflow together");
  a_a_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide && a_fnd_q |-> CW'(a_q) < cnt_q) else $error("found slot beyond count");
`endif

endmodule
`default_nettype wire

@@ dv/free_id_range_set_tb.sv @@
// testbench for free_id_range_set: drives requests on the input stream and
// checks every result transfer against an in-bench model of the range table
// depends on frs_pkg and the free_id_range_set rtl
`default_nettype none
module free_id_range_set_tb;
  import frs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TABLE_SLOTS = 64;
  localparam logic [2:0]  FN_SPARE_LO = 3'd5;
  localparam logic [2:0]  FN_SPARE_HI = 3'd7;
  localparam logic [31:0] ID_TOP      = 32'hFFFF_FFFF;
  localparam int          ID_WINDOW   = 4095;

  typedef struct {
    logic [31:0] id;
    logic        hit;
    logic        ovf;
  } id_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  free_id_range_set dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #5 clk_i = ~clk_i;

  // model of the free range table
  logic [32:0] free_lo [TABLE_SLOTS];
  logic [32:0] free_hi [TABLE_SLOTS];
  int          free_count = 0;

  id_result_t  pending_results[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_req = 0;
  int          hold_left = 0;
  bit          failed = 1'b0;

  function automatic void drop_range(int k);
    for (int m = k; m + 1 < free_count; m++) begin
      free_lo[m] = free_lo[m + 1];
      free_hi[m] = free_hi[m + 1];
    end
    free_count--;
  endfunction

  function automatic void open_range(int k);
    for (int m = free_count; m > k; m--) begin
      free_lo[m] = free_lo[m - 1];
      free_hi[m] = free_hi[m - 1];
    end
    free_count++;
  endfunction

  // 0 empty range, 1 united, 2 table full
  function automatic int unite_range(logic [32:0] lo, logic [32:0] hi);
    int a = 0;
    int b;
    logic [32:0] ns, ne;
    if (lo >= hi) return 0;
    while (a < free_count && free_hi[a] < lo) a++;
    b = a;
    while (b < free_count && free_lo[b] <= hi) b++;
    if (a == b) begin
      if (free_count >= TABLE_SLOTS) return 2;
      open_range(a);
      free_lo[a] = lo;
      free_hi[a] = hi;
      return 1;
    end
    ns = free_lo[a] < lo ? free_lo[a] : lo;
    ne = free_hi[b - 1] > hi ? free_hi[b - 1] : hi;
    free_lo[a] = ns;
    free_hi[a] = ne;
    for (int k = a + 1; k < b; k++) drop_range(a + 1);
    return 1;
  endfunction

  function automatic bit carve_id(int k, logic [32:0] id);
    if (id == free_lo[k]) begin
      free_lo[k] = id + 1;
      if (free_lo[k] == free_hi[k]) drop_range(k);
      return 1'b1;
    end
    if (id + 1 == free_hi[k]) begin
      free_hi[k] = id;
      return 1'b1;
    end
    if (free_count >= TABLE_SLOTS) return 1'b0;
    open_range(k + 1);
    free_lo[k + 1] = id + 1;
    free_hi[k + 1] = free_hi[k];
    free_hi[k] = id;
    return 1'b1;
  endfunction

  function automatic id_result_t predict_request(logic [2:0] fn, logic [31:0] lo_i,
                                                 logic [31:0] hi_i);
    id_result_t  r = '{id: '0, hit: 1'b0, ovf: 1'b0};
    logic [32:0] lo = {1'b0, lo_i};
    logic [32:0] id;
    int          k = 0;
    int          st;
    case (fn)
      FN_ADD: begin
        st = unite_range(lo, {1'b0, hi_i});
        r.hit = (st == 1);
        r.ovf = (st == 2);
      end
      FN_HAS: begin
        for (k = 0; k < free_count; k++)
          if (lo >= free_lo[k] && lo < free_hi[k]) r.hit = 1'b1;
      end
      FN_GET: begin
        if (free_count > 0) begin
          r.id = free_lo[0][31:0];
          void'(carve_id(0, free_lo[0]));
          r.hit = 1'b1;
        end
      end
      FN_SELECT, FN_START: begin
        while (k < free_count && free_hi[k] <= lo) k++;
        if (k < free_count) begin
          id = lo;
          if (id < free_lo[k]) begin
            if (fn == FN_SELECT) k = free_count;
            else id = free_lo[k];
          end
          if (k < free_count) begin
            if (carve_id(k, id)) begin
              r.id = id[31:0];
              r.hit = 1'b1;
            end else begin
              r.ovf = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(logic [2:0] fn, logic [31:0] lo, logic [31:0] hi);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hi, lo};
    s_axis_tuser  <= fn;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_request(fn, lo, hi));
  endtask

  task automatic release_sender();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // receiver readiness, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    id_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result id %h flags %b", $time, m_axis_tdata, m_axis_tuser);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.id) begin
          $display("%0t: result_id expected %h actual %h", $time, want.id, m_axis_tdata);
          failed = 1'b1;
        end
        if (m_axis_tuser[0] !== want.hit) begin
          $display("%0t: hit expected %b actual %b", $time, want.hit, m_axis_tuser[0]);
          failed = 1'b1;
        end
        if (m_axis_tuser[1] !== want.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, want.ovf, m_axis_tuser[1]);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic test_empty_set();
    send_request(FN_GET, '0, '0);
    send_request(FN_SELECT, 32'd7, '0);
    send_request(FN_START, '0, '0);
    send_request(FN_HAS, ID_TOP, '0);
    send_request(FN_ADD, 32'd9, 32'd9);
    send_request(FN_ADD, ID_TOP, '0);
    for (logic [3:0] f = {1'b0, FN_SPARE_LO}; f <= {1'b0, FN_SPARE_HI}; f++)
      send_request(f[2:0], ID_TOP, ID_TOP);
    release_sender();
  endtask

  task automatic test_full_table();
    logic [31:0] base;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      base = 32'd1000 + 32'(4 * i);
      send_request(FN_ADD, base, base + 3);
    end
    send_request(FN_ADD, 32'd10, 32'd20);
    send_request(FN_ADD, 32'd1000, 32'd1001);
    send_request(FN_SELECT, 32'd1001, '0);
    send_request(FN_START, 32'd1001, '0);
    send_request(FN_START, 32'd1003, '0);
    send_request(FN_SELECT, 32'd1004, '0);
    send_request(FN_ADD, 32'd0, ID_TOP);
    send_request(FN_HAS, ID_TOP - 1, '0);
    send_request(FN_HAS, ID_TOP, '0);
    release_sender();
  endtask

  task automatic test_edges();
    send_request(FN_GET, '0, '0);
    send_request(FN_SELECT, ID_TOP - 1, '0);
    send_request(FN_START, ID_TOP - 1, '0);
    send_request(FN_SELECT, 32'h8000_0000, '0);
    send_request(FN_SELECT, 32'h8000_0000, '0);
    send_request(FN_START, 32'h8000_0000, '0);
    send_request(FN_ADD, ID_TOP - 5, ID_TOP);
    send_request(FN_ADD, 32'h8000_0000, 32'h8000_0001);
    send_request(FN_HAS, 32'h8000_0000, '0);
    send_request(FN_START, ID_TOP, '0);
    release_sender();
  endtask

  task automatic random_request();
    int          pick = $urandom_range(99);
    logic [31:0] lo = $urandom_range(ID_WINDOW);
    logic [31:0] hi = lo + $urandom_range(16, 1);
    logic [2:0]  fn;
    if ($urandom_range(9) == 0) begin
      lo = $urandom;
      hi = $urandom;
    end else if ($urandom_range(19) == 0) begin
      hi = lo - $urandom_range(1, 0);
    end
    if (pick < 35) fn = FN_ADD;
    else if (pick < 45) fn = FN_HAS;
    else if (pick < 60) fn = FN_GET;
    else if (pick < 80) fn = FN_SELECT;
    else if (pick < 95) fn = FN_START;
    else fn = 3'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
    send_request(fn, lo, hi);
  endtask

  task automatic test_random(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) random_request();
    release_sender();
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    hold_req = 400;
    repeat (12) random_request();
    release_sender();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_set();
    test_full_table();
    test_edges();
    test_output_stall();
    test_random(285, 22, 81);
    test_random(285, 81, 22);
    test_random(285, 0, 0);
    recv_idle_pct = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (!failed) $display("free_id_range_set_tb passed");
    else $display("free_id_range_set_tb failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("free_id_range_set_tb failed");
    $finish;
  end

endmodule
`default_nettype wire
